// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SBPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SBPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sbpt_pkg.sv -----
// ----------------------------------------------------------------------------
// sbpt_pkg
// Types and constants of the servo bus packet transceiver.
// ----------------------------------------------------------------------------
package sbpt_pkg;

  // input operations
  localparam logic [2:0] OP_START_TX = 3'd0;
  localparam logic [2:0] OP_TX_PARAM = 3'd1;
  localparam logic [2:0] OP_RX_START = 3'd2;
  localparam logic [2:0] OP_RX_BYTE  = 3'd3;
  localparam logic [2:0] OP_TICK     = 3'd4;

  // result kinds
  localparam logic [2:0] KIND_TX_BYTE  = 3'd0;
  localparam logic [2:0] KIND_RX_BYTE  = 3'd1;
  localparam logic [2:0] KIND_RX_EMPTY = 3'd2;
  localparam logic [2:0] KIND_RX_BAD   = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT  = 3'd4;

  // queued commands
  localparam logic [1:0] CMD_TX_HDR = 2'd0;
  localparam logic [1:0] CMD_TX_PAR = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;
  localparam logic [1:0] CMD_DUMP   = 2'd3;

  // framing constants
  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [7:0] LEN_BIAS    = 8'd2;
  localparam logic [5:0] HDR_BYTES   = 6'd6;
  localparam logic [5:0] PAY_OFS     = 6'd5;
  localparam logic [5:0] ID_POS      = 6'd2;
  localparam logic [7:0] TIMEOUT_RST = 8'd15;
  localparam logic [7:0] TIMER_MAX   = 8'hFF;

  // command queue depth
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW    = 2;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] dev_id;
    logic [7:0] instr;
    logic [7:0] data_byte;
    logic [4:0] count;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // one queued command: header, parameter, status or payload dump
  typedef struct packed {
    logic [1:0] code;
    logic [7:0] b0;      // id, parameter byte or status kind
    logic [7:0] b1;      // length field
    logic [7:0] b2;      // instruction
    logic [7:0] ck;      // checksum
    logic       has_ck;
    logic [4:0] n;       // payload bytes to dump
  } cmd_t;

  // payload store write port
  typedef struct packed {
    logic       en;
    logic [5:0] addr;
    logic [7:0] data;
  } pay_wr_t;

endpackage

// ----- rtl/core/servo_bus_packet_transceiver.sv -----
// ----------------------------------------------------------------------------
// servo_bus_packet_transceiver
// Half-duplex servo bus packet framer and deframer.
// ----------------------------------------------------------------------------
// The front end takes one input transaction per cycle unless the four-entry
// command queue is full; a received byte also waits while a payload dump of
// the previous response is still being read out of the payload store. The
// back end loads each command into its command register, then puts out one
// result per cycle for transmit bytes and status results while out_stall is
// low; a payload byte waits for the registered read of the payload store. A
// start_tx gives 5 or 6 results, a tx_param of an active transmit 1 or 2, a
// complete response 1 status result or up to MAX_PACKET-6 payload bytes, a
// timeout tick one. The always-ready cfg port writes the timeout register.
// ----------------------------------------------------------------------------
module servo_bus_packet_transceiver
  import sbpt_pkg::*;
#(
  parameter int unsigned MAX_PACKET = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic    q_push, q_full, q_pop, q_empty, dump_done;
  cmd_t    q_in, q_out;
  pay_wr_t pay_wr;

  assign cfg_ready = 1'b1;

  sbpt_front #(.MAX_PACKET(MAX_PACKET)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_cmd     (q_in),
    .q_full    (q_full),
    .pay_wr    (pay_wr),
    .dump_done (dump_done)
  );

  sbpt_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  sbpt_back #(.MAX_PACKET(MAX_PACKET)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_out),
    .q_pop     (q_pop),
    .pay_wr    (pay_wr),
    .dump_done (dump_done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- rtl/core/sbpt_front.sv -----
// ----------------------------------------------------------------------------
// sbpt_front
// Accepts input items, keeps framer and deframer state, queues commands.
// ----------------------------------------------------------------------------
module sbpt_front
  import sbpt_pkg::*;
#(
  parameter int unsigned MAX_PACKET = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     cfg_valid,
  input  logic     [7:0] cfg_data,
  output logic     q_push,
  output cmd_t     q_cmd,
  input  logic     q_full,
  output pay_wr_t  pay_wr,
  input  logic     dump_done
);

  localparam logic [5:0] CAP_W = 6'(MAX_PACKET - 6);

  logic [7:0] timeout_r;
  logic       tx_active_r, tx_active_nxt;
  logic [4:0] tx_rem_r, tx_rem_nxt;
  logic [7:0] tx_sum_r, tx_sum_nxt;
  logic       rx_armed_r, rx_armed_nxt;
  logic [7:0] rx_id_r, rx_id_nxt;
  logic [4:0] rx_exp_r, rx_exp_nxt;
  logic [5:0] rx_rcv_r, rx_rcv_nxt;
  logic       rx_ok_r, rx_ok_nxt;
  logic [7:0] rx_timer_r, rx_timer_nxt;
  logic       dump_pend_r, dump_pend_nxt;

  logic       accept;
  logic [4:0] cnt_c;
  logic [7:0] len_c, sum_c, psum_c, tick_c;
  logic [4:0] prem_c;
  logic [5:0] pos_off;

  // payload store is busy while a dump is pending; received bytes wait
  assign in_stall = q_full || (in_data.op == OP_RX_BYTE && dump_pend_r);
  assign accept   = in_valid && !in_stall;

  // clamped count and transmit arithmetic
  assign cnt_c   = ({1'b0, in_data.count} > CAP_W) ? CAP_W[4:0] : in_data.count;
  assign len_c   = {3'd0, cnt_c} + LEN_BIAS;
  assign sum_c   = in_data.dev_id + len_c + in_data.instr;
  assign psum_c  = tx_sum_r + in_data.data_byte;
  assign prem_c  = tx_rem_r - 5'd1;
  assign tick_c  = (rx_timer_r < TIMER_MAX) ? rx_timer_r + 8'd1 : rx_timer_r;
  assign pos_off = rx_rcv_r - PAY_OFS;

  always_comb begin
    tx_active_nxt = tx_active_r;
    tx_rem_nxt    = tx_rem_r;
    tx_sum_nxt    = tx_sum_r;
    rx_armed_nxt  = rx_armed_r;
    rx_id_nxt     = rx_id_r;
    rx_exp_nxt    = rx_exp_r;
    rx_rcv_nxt    = rx_rcv_r;
    rx_ok_nxt     = rx_ok_r;
    rx_timer_nxt  = rx_timer_r;
    dump_pend_nxt = dump_pend_r && !dump_done;
    q_push        = 1'b0;
    q_cmd         = '0;
    pay_wr        = '0;
    if (accept) begin
      unique case (in_data.op)
        OP_START_TX: begin
          q_push        = 1'b1;
          q_cmd.code    = CMD_TX_HDR;
          q_cmd.b0      = in_data.dev_id;
          q_cmd.b1      = len_c;
          q_cmd.b2      = in_data.instr;
          q_cmd.ck      = ~sum_c;
          q_cmd.has_ck  = (cnt_c == 5'd0);
          tx_sum_nxt    = sum_c;
          tx_rem_nxt    = cnt_c;
          tx_active_nxt = (cnt_c != 5'd0);
          rx_armed_nxt  = 1'b0;
        end
        OP_TX_PARAM: begin
          if (tx_active_r) begin
            q_push        = 1'b1;
            q_cmd.code    = CMD_TX_PAR;
            q_cmd.b0      = in_data.data_byte;
            q_cmd.ck      = ~psum_c;
            q_cmd.has_ck  = (prem_c == 5'd0);
            tx_sum_nxt    = psum_c;
            tx_rem_nxt    = prem_c;
            tx_active_nxt = (prem_c != 5'd0);
          end
        end
        OP_RX_START: begin
          rx_armed_nxt = 1'b1;
          rx_id_nxt    = in_data.dev_id;
          rx_exp_nxt   = cnt_c;
          rx_rcv_nxt   = '0;
          rx_ok_nxt    = 1'b1;
          rx_timer_nxt = '0;
        end
        OP_RX_BYTE: begin
          if (rx_armed_r) begin
            // header checks: two sync bytes, then the id
            if (rx_rcv_r < ID_POS && in_data.data_byte != SYNC_BYTE) begin
              rx_ok_nxt = 1'b0;
            end
            if (rx_rcv_r == ID_POS && in_data.data_byte != rx_id_r) begin
              rx_ok_nxt = 1'b0;
            end
            // payload capture
            if (rx_rcv_r >= PAY_OFS && pos_off < {1'b0, rx_exp_r}) begin
              pay_wr.en   = 1'b1;
              pay_wr.addr = pos_off;
              pay_wr.data = in_data.data_byte;
            end
            rx_rcv_nxt = rx_rcv_r + 6'd1;
            // frame complete
            if (rx_rcv_nxt >= HDR_BYTES + {1'b0, rx_exp_r}) begin
              rx_armed_nxt = 1'b0;
              q_push       = 1'b1;
              priority if (!rx_ok_nxt) begin
                q_cmd.code = CMD_STATUS;
                q_cmd.b0   = {5'd0, KIND_RX_BAD};
              end else if (rx_exp_r == 5'd0) begin
                q_cmd.code = CMD_STATUS;
                q_cmd.b0   = {5'd0, KIND_RX_EMPTY};
              end else begin
                q_cmd.code    = CMD_DUMP;
                q_cmd.n       = rx_exp_r;
                dump_pend_nxt = 1'b1;
              end
            end
          end
        end
        OP_TICK: begin
          if (rx_armed_r) begin
            rx_timer_nxt = tick_c;
            if (tick_c >= timeout_r) begin
              q_push       = 1'b1;
              q_cmd.code   = CMD_STATUS;
              q_cmd.b0     = {5'd0, KIND_TIMEOUT};
              rx_armed_nxt = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      tx_active_r <= 1'b0;
      tx_rem_r    <= '0;
      tx_sum_r    <= '0;
      rx_armed_r  <= 1'b0;
      rx_id_r     <= '0;
      rx_exp_r    <= '0;
      rx_rcv_r    <= '0;
      rx_ok_r     <= 1'b1;
      rx_timer_r  <= '0;
      dump_pend_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        timeout_r <= cfg_data;
      end
      tx_active_r <= tx_active_nxt;
      tx_rem_r    <= tx_rem_nxt;
      tx_sum_r    <= tx_sum_nxt;
      rx_armed_r  <= rx_armed_nxt;
      rx_id_r     <= rx_id_nxt;
      rx_exp_r    <= rx_exp_nxt;
      rx_rcv_r    <= rx_rcv_nxt;
      rx_ok_r     <= rx_ok_nxt;
      rx_timer_r  <= rx_timer_nxt;
      dump_pend_r <= dump_pend_nxt;
    end
  end

endmodule

// ----- rtl/core/sbpt_cmdq.sv -----
// ----------------------------------------------------------------------------
// sbpt_cmdq
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module sbpt_cmdq
  import sbpt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wp_r, rp_r;
  logic [CMDQ_AW:0]   cnt_r;

  assign full     = (cnt_r == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (CMDQ_AW + 1)'(push) - (CMDQ_AW + 1)'(pop);
    end
  end

endmodule

// ----- rtl/core/sbpt_back.sv -----
// ----------------------------------------------------------------------------
// sbpt_back
// Expands queued commands into result transactions; holds the payload store.
// ----------------------------------------------------------------------------
module sbpt_back
  import sbpt_pkg::*;
#(
  parameter int unsigned MAX_PACKET = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  input  pay_wr_t   pay_wr,
  output logic      dump_done,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int unsigned CAP = MAX_PACKET - 6;
  localparam int unsigned PW  = (CAP > 1) ? $clog2(CAP) : 1;

  logic [7:0] pay_mem [CAP];
  logic [7:0] rd_data_r;
  logic       rd_pend_r;

  cmd_t       cur_r;
  logic       active_r;
  logic [5:0] step_r;
  logic       out_valid_r;
  out_item_t  out_item_r;

  logic       slot_free, emit, is_last, rd_go;
  out_item_t  gen;

  assign slot_free = !out_valid_r || !out_stall;
  assign emit      = active_r && slot_free && (cur_r.code != CMD_DUMP || rd_pend_r);
  assign rd_go     = active_r && cur_r.code == CMD_DUMP && !rd_pend_r;
  assign q_pop     = !active_r && !q_empty;
  assign dump_done = emit && is_last && cur_r.code == CMD_DUMP;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // result for the current step
  always_comb begin
    gen     = '0;
    is_last = 1'b0;
    unique case (cur_r.code)
      CMD_TX_HDR: begin
        gen.kind = KIND_TX_BYTE;
        unique case (step_r)
          6'd0, 6'd1: gen.out_byte = SYNC_BYTE;
          6'd2:       gen.out_byte = cur_r.b0;
          6'd3:       gen.out_byte = cur_r.b1;
          6'd4:       gen.out_byte = cur_r.b2;
          default:    gen.out_byte = cur_r.ck;
        endcase
        is_last = (step_r == (cur_r.has_ck ? 6'd5 : 6'd4));
      end
      CMD_TX_PAR: begin
        gen.kind     = KIND_TX_BYTE;
        gen.out_byte = (step_r == 6'd0) ? cur_r.b0 : cur_r.ck;
        is_last      = (step_r == (cur_r.has_ck ? 6'd1 : 6'd0));
      end
      CMD_STATUS: begin
        gen.kind = cur_r.b0[2:0];
        is_last  = 1'b1;
      end
      CMD_DUMP: begin
        gen.kind     = KIND_RX_BYTE;
        gen.out_byte = rd_data_r;
        is_last      = (step_r == {1'b0, cur_r.n} - 6'd1);
      end
      default: begin
      end
    endcase
    gen.last = is_last;
  end

  // payload store: write from the front, registered read for dumps
  always_ff @(posedge clk) begin
    if (pay_wr.en) begin
      pay_mem[pay_wr.addr[PW-1:0]] <= pay_wr.data;
    end
    if (rd_go) begin
      rd_data_r <= pay_mem[step_r[PW-1:0]];
    end
  end

  // command register and step counter
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      step_r    <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      if (q_pop) begin
        active_r  <= 1'b1;
        step_r    <= '0;
        rd_pend_r <= 1'b0;
      end else begin
        if (rd_go) begin
          rd_pend_r <= 1'b1;
        end
        if (emit) begin
          rd_pend_r <= 1'b0;
          step_r    <= step_r + 6'd1;
          if (is_last) begin
            active_r <= 1'b0;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= gen;
    end
  end

endmodule

// ----- rtl/core/sbpt_checker.sv -----
// ----------------------------------------------------------------------------
// sbpt_checker
// Port-level checks on the result channel of the transceiver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbpt_checker
  import sbpt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // a stalled result transaction holds
  `SBPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(out_item), "result changed while stalled")

  // only defined kinds appear
  `SBPT_ASSERT_NOW(a_kind_range, out_valid, out_item.kind <= KIND_TIMEOUT,
                   "undefined result kind")

  // status results stand alone and carry no byte
  `SBPT_ASSERT_NOW(a_status_form, out_valid && out_item.kind >= KIND_RX_EMPTY,
                   out_item.last && out_item.out_byte == 8'd0, "malformed status result")

endmodule

bind servo_bus_packet_transceiver sbpt_checker u_sbpt_checker (.*);
